>>> design/tcaq_pkg.sv
`timescale 1ns / 1ps
// shared types, register indexes and helper functions of the three-channel alarm qualifier
// no dependencies
`default_nettype none

package tcaq_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned HOLD_MS_W   = 26;
   localparam int unsigned MS_PER_S    = 1000;
   localparam logic [15:0] SETTLE_RESET = 16'd1000;

   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE_MASK   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IR_ACT_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_GATE_ACT_HIGH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_INPUT1_ROLE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_INPUT2_ROLE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_IR_HOLD_S     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_GATE_HOLD_S   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SETTLE_MS     = 3'd7;

   localparam logic [1:0] ROLE_GATE     = 2'd1;
   localparam logic [1:0] ROLE_INFRARED = 2'd2;

   localparam logic [3:0] CODE_MIXED    = 4'd0;
   localparam logic [3:0] CODE_CLOSE    = 4'd1;
   localparam logic [3:0] CODE_T        = 4'd2;
   localparam logic [3:0] CODE_G        = 4'd3;
   localparam logic [3:0] CODE_I        = 4'd4;
   localparam logic [3:0] CODE_TG       = 4'd5;
   localparam logic [3:0] CODE_TI       = 4'd6;
   localparam logic [3:0] CODE_GI       = 4'd7;
   localparam logic [3:0] CODE_ALL      = 4'd8;
   localparam logic [3:0] CODE_CONFIRM  = 4'd9;

   typedef enum logic [2:0] {
      ST_NORMAL    = 3'd0,
      ST_ON_DELAY  = 3'd1,
      ST_HOLD      = 3'd2,
      ST_OFF_DELAY = 3'd3,
      ST_RUN       = 3'd4
   } chan_state_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        confirm;
      logic        tamper_level;
      logic        input1_level;
      logic        input2_level;
   } req_type;

   typedef struct packed {
      logic       alarm_active;
      logic       alarm_raised;
      logic       alarm_cleared;
      logic [2:0] log_mask;
      logic       display_update;
      logic [3:0] display_code;
      logic [2:0] tamper_status;
      logic [2:0] gate_status;
      logic [2:0] infrared_status;
   } rsp_type;

   typedef struct packed {
      chan_state_type status;
      logic           last;
      logic           load_start;
      logic           log_run;
      logic           refresh;
   } chan_next_type;

   // display code from a snapshot of the three channel states
   function automatic logic [3:0] refresh_code(input chan_state_type s0,
                                               input chan_state_type s1,
                                               input chan_state_type s2);
      logic [2:0] runs;
      logic       other;
      logic [3:0] code;
      runs  = {s2 == ST_RUN, s1 == ST_RUN, s0 == ST_RUN};
      other = (s0 != ST_RUN && s0 != ST_NORMAL) || (s1 != ST_RUN && s1 != ST_NORMAL) ||
              (s2 != ST_RUN && s2 != ST_NORMAL);
      unique case (runs)
         3'b000:  code = CODE_CLOSE;
         3'b001:  code = CODE_T;
         3'b010:  code = CODE_G;
         3'b100:  code = CODE_I;
         3'b011:  code = CODE_TG;
         3'b101:  code = CODE_TI;
         3'b110:  code = CODE_GI;
         default: code = CODE_ALL;
      endcase
      return other ? CODE_MIXED : code;
   endfunction

   // one poll of one channel qualifier
   function automatic chan_next_type chan_step(input chan_state_type stat,
                                               input logic last,
                                               input logic [31:0] start,
                                               input logic sig,
                                               input logic [31:0] now,
                                               input logic en,
                                               input logic has_hold,
                                               input logic [HOLD_MS_W-1:0] hold_ms,
                                               input logic [15:0] settle);
      chan_next_type r;
      logic [31:0]   elapsed;
      logic          settle_done;
      logic          hold_done;
      elapsed     = now - start;
      settle_done = elapsed > {16'd0, settle};
      hold_done   = elapsed > {{(32-HOLD_MS_W){1'b0}}, hold_ms};
      r.status     = stat;
      r.last       = sig;
      r.load_start = 1'b0;
      r.log_run    = 1'b0;
      r.refresh    = 1'b0;
      if (!en) begin
         if (stat == ST_RUN) r.status = ST_NORMAL;
         r.last = 1'b0;
      end else begin
         unique case (stat)
            ST_NORMAL: begin
               if (sig && !last) begin
                  r.status     = ST_ON_DELAY;
                  r.load_start = 1'b1;
               end
            end
            ST_ON_DELAY: begin
               if (!sig) begin
                  r.status = ST_NORMAL;
               end else if (settle_done) begin
                  if (has_hold) begin
                     r.status     = ST_HOLD;
                     r.load_start = 1'b1;
                  end else begin
                     r.status  = ST_RUN;
                     r.log_run = 1'b1;
                     r.refresh = 1'b1;
                  end
               end
            end
            ST_HOLD: begin
               if (!sig) begin
                  r.status = ST_NORMAL;
               end else if (hold_done) begin
                  r.status  = ST_RUN;
                  r.log_run = 1'b1;
                  r.refresh = 1'b1;
               end
            end
            ST_OFF_DELAY: begin
               if (sig) begin
                  r.status = ST_RUN;
               end else if (settle_done) begin
                  r.status  = ST_NORMAL;
                  r.refresh = 1'b1;
               end
            end
            ST_RUN: begin
               if (!sig) begin
                  r.status     = ST_OFF_DELAY;
                  r.load_start = 1'b1;
               end
            end
            default: ;
         endcase
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> design/three_channel_alarm_qualifier.sv
`timescale 1ns / 1ps
// three-channel alarm qualifier: input register, one pass of channel and master logic,
// result register. depends on tcaq_pkg
// an item is held in the input register until the output is free, then in the result register
// throughput: one item per cycle if not stalled; channel state update is one registered pass
// reset (synchronous, active high) returns every channel to normal, clears the master latch,
// edge memory and display code, and loads the register defaults (settle 1000 ms, others 0)
`default_nettype none

module three_channel_alarm_qualifier (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire tcaq_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output tcaq_pkg::rsp_type                     rsp_data,
   input  wire                                   csr_we,
   input  wire [tcaq_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire [tcaq_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import tcaq_pkg::*;

   // configuration
   logic [2:0]           enable_mask_ff;
   logic                 ir_act_high_ff;
   logic                 gate_act_high_ff;
   logic [1:0]           input1_role_ff;
   logic [1:0]           input2_role_ff;
   logic [HOLD_MS_W-1:0] ir_hold_ms_ff;
   logic [HOLD_MS_W-1:0] gate_hold_ms_ff;
   logic [15:0]          settle_ms_ff;

   // pipeline
   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;
   logic    out_free, move;

   // channel state
   chan_state_type status_ff [3];
   chan_state_type status_in [3];
   chan_state_type st0 [3];
   logic [2:0]     last_ff, last_in;
   logic [31:0]    start_ff [3];
   logic [31:0]    start_in [3];
   logic           master_ff, master_in;
   logic [3:0]     code_ff, code_in;

   chan_next_type  nx [3];
   logic           gate_sel1, gate_sel2, gate_en, gate_sig;
   logic           ir_en, ir_lv, ir_sig;
   logic           any_run, master_base;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign move      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !move);
   assign rsp_valid_in = move || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff   <= '0;
         ir_act_high_ff   <= 1'b0;
         gate_act_high_ff <= 1'b0;
         input1_role_ff   <= '0;
         input2_role_ff   <= '0;
         ir_hold_ms_ff    <= '0;
         gate_hold_ms_ff  <= '0;
         settle_ms_ff     <= SETTLE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ENABLE_MASK:   enable_mask_ff   <= csr_wdata[2:0];
            REG_IR_ACT_HIGH:   ir_act_high_ff   <= csr_wdata[0];
            REG_GATE_ACT_HIGH: gate_act_high_ff <= csr_wdata[0];
            REG_INPUT1_ROLE:   input1_role_ff   <= csr_wdata[1:0];
            REG_INPUT2_ROLE:   input2_role_ff   <= csr_wdata[1:0];
            // hold stored in ms so the poll path only compares
            REG_IR_HOLD_S:     ir_hold_ms_ff    <= HOLD_MS_W'(csr_wdata * MS_PER_S);
            REG_GATE_HOLD_S:   gate_hold_ms_ff  <= HOLD_MS_W'(csr_wdata * MS_PER_S);
            REG_SETTLE_MS:     settle_ms_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         master_ff    <= 1'b0;
         code_ff      <= '0;
         last_ff      <= '0;
         for (int i = 0; i < 3; i++) begin
            status_ff[i] <= ST_NORMAL;
            start_ff[i]  <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (move) begin
            master_ff <= master_in;
            code_ff   <= code_in;
            last_ff   <= last_in;
            for (int i = 0; i < 3; i++) begin
               status_ff[i] <= status_in[i];
               start_ff[i]  <= start_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_ff <= req_data;
      if (move) rsp_ff <= rsp_in;
   end

   always_comb begin
      // confirm drops running channels before the channel steps
      for (int i = 0; i < 3; i++)
         st0[i] = (in_ff.confirm && status_ff[i] == ST_RUN) ? ST_NORMAL : status_ff[i];

      gate_sel1 = input1_role_ff == ROLE_GATE;
      gate_sel2 = input2_role_ff == ROLE_GATE;
      gate_en   = enable_mask_ff[1] && (gate_sel1 || gate_sel2);
      gate_sig  = (gate_sel1 && (in_ff.input1_level == gate_act_high_ff)) ||
                  (gate_sel2 && (in_ff.input2_level == gate_act_high_ff));

      ir_en  = enable_mask_ff[2] &&
               (input1_role_ff == ROLE_INFRARED || input2_role_ff == ROLE_INFRARED);
      ir_lv  = (input1_role_ff == ROLE_INFRARED) ? in_ff.input1_level : in_ff.input2_level;
      ir_sig = ir_lv == ir_act_high_ff;

      nx[0] = chan_step(st0[0], last_ff[0], start_ff[0], in_ff.tamper_level, in_ff.now_ms,
                        enable_mask_ff[0], 1'b0, '0, settle_ms_ff);
      nx[1] = chan_step(st0[1], last_ff[1], start_ff[1], gate_sig, in_ff.now_ms,
                        gate_en, 1'b1, gate_hold_ms_ff, settle_ms_ff);
      nx[2] = chan_step(st0[2], last_ff[2], start_ff[2], ir_sig, in_ff.now_ms,
                        ir_en, 1'b1, ir_hold_ms_ff, settle_ms_ff);

      for (int i = 0; i < 3; i++) begin
         status_in[i] = nx[i].status;
         last_in[i]   = nx[i].last;
         start_in[i]  = nx[i].load_start ? in_ff.now_ms : start_ff[i];
      end

      // later channels are seen as not yet stepped; the last request wins
      code_in = in_ff.confirm ? CODE_CONFIRM : code_ff;
      if (nx[0].refresh) code_in = refresh_code(nx[0].status, st0[1], st0[2]);
      if (nx[1].refresh) code_in = refresh_code(nx[0].status, nx[1].status, st0[2]);
      if (nx[2].refresh) code_in = refresh_code(nx[0].status, nx[1].status, nx[2].status);

      any_run     = nx[0].status == ST_RUN || nx[1].status == ST_RUN ||
                    nx[2].status == ST_RUN;
      master_base = in_ff.confirm ? 1'b0 : master_ff;
      master_in   = any_run;

      rsp_in.alarm_active    = any_run;
      rsp_in.alarm_raised    = !master_base && any_run;
      rsp_in.alarm_cleared   = in_ff.confirm || (master_base && !any_run);
      rsp_in.log_mask        = {nx[2].log_run, nx[1].log_run, nx[0].log_run};
      rsp_in.display_update  = in_ff.confirm || nx[0].refresh || nx[1].refresh ||
                               nx[2].refresh;
      rsp_in.display_code    = code_in;
      rsp_in.tamper_status   = 3'(nx[0].status);
      rsp_in.gate_status     = 3'(nx[1].status);
      rsp_in.infrared_status = 3'(nx[2].status);
   end

   // master latch follows whether any channel runs
   a_master_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.alarm_active ==
         (rsp_ff.tamper_status == 3'(ST_RUN) || rsp_ff.gate_status == 3'(ST_RUN) ||
          rsp_ff.infrared_status == 3'(ST_RUN)))
      else $error("alarm latch disagrees with channel states");

   a_raise_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.alarm_raised |-> rsp_ff.alarm_active)
      else $error("raise pulse without active alarm");

   a_log_refresh: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.log_mask != 3'd0 |-> rsp_ff.display_update)
      else $error("channel entered run without display refresh");

   a_move_result: assert property (@(posedge clock) disable iff (reset)
      move |=> rsp_valid_ff)
      else $error("item processed but no result held");

   a_master_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_stall |-> master_ff == rsp_ff.alarm_active || in_valid_ff)
      else $error("master latch out of step with last result");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for three_channel_alarm_qualifier: random bursts of polls against a
// cycle-free model of the three channel qualifiers and the master latch; depends on tcaq_pkg

module tb_top;

   import tcaq_pkg::*;

   localparam int RUN_LIMIT  = 200000;
   localparam int CH_TAMPER  = 0;
   localparam int CH_GATE    = 1;
   localparam int CH_IR      = 2;
   localparam logic [1:0] ROLE_OTHER = 2'd0;
   localparam logic [1:0] ROLE_SPARE = 2'd3;
   localparam logic [2:0] EN_TAMPER  = 3'b001;
   localparam logic [2:0] EN_GATE    = 3'b010;
   localparam logic [2:0] EN_IR      = 3'b100;

   typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HALF, FLOW_HEAVY} flow_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // model state and register copy
   chan_state_type chan_model [3] = '{ST_NORMAL, ST_NORMAL, ST_NORMAL};
   logic           chan_last  [3] = '{1'b0, 1'b0, 1'b0};
   logic [31:0]    chan_start [3] = '{32'd0, 32'd0, 32'd0};
   logic           master_on  = 1'b0;
   logic [3:0]     shown_code = 4'd0;
   logic [2:0]     cfg_enable = 3'd0;
   logic           cfg_ir_hi = 1'b0;
   logic           cfg_gate_hi = 1'b0;
   logic [1:0]     cfg_role1 = 2'd0;
   logic [1:0]     cfg_role2 = 2'd0;
   logic [15:0]    cfg_ir_hold = 16'd0;
   logic [15:0]    cfg_gate_hold = 16'd0;
   logic [15:0]    cfg_settle = SETTLE_RESET;

   req_type        pending_polls  [$];
   rsp_type        expected_polls [$];
   int             polls_queued = 0;
   int             polls_accepted = 0;
   int             error_count = 0;
   int             cycle_count = 0;
   logic           req_taken = 1'b0;

   // stimulus generator state
   logic [31:0]    poll_ms = 32'd0;
   logic           lv_tamper = 1'b0;
   logic           lv_in1 = 1'b0;
   logic           lv_in2 = 1'b0;

   int             gap_left = 0;
   int             burst_left = 0;
   logic           drain_hold = 1'b0;
   flow_type       stall_mode = FLOW_FREE;
   int             stall_left = 0;

   three_channel_alarm_qualifier DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [3:0] run_pattern_code();
      logic [2:0] runs;
      runs = 3'b000;
      for (int c = 0; c < 3; c++) begin
         if (chan_model[c] == ST_RUN) runs[c] = 1'b1;
         else if (chan_model[c] != ST_NORMAL) return CODE_MIXED;
      end
      case (runs)
         3'b000:  return CODE_CLOSE;
         3'b001:  return CODE_T;
         3'b010:  return CODE_G;
         3'b100:  return CODE_I;
         3'b011:  return CODE_TG;
         3'b101:  return CODE_TI;
         3'b110:  return CODE_GI;
         default: return CODE_ALL;
      endcase
   endfunction

   task automatic advance_channel(input int c, input logic on, input logic sig,
                                  input logic [31:0] now, input logic has_hold,
                                  input logic [31:0] hold_ms, inout logic [2:0] log_bits,
                                  inout logic upd);
      logic [31:0] elapsed;
      elapsed = now - chan_start[c];
      if (!on) begin
         // disabled or unassigned: only a running channel drops, the rest freeze
         if (chan_model[c] == ST_RUN) chan_model[c] = ST_NORMAL;
         chan_last[c] = 1'b0;
      end else begin
         case (chan_model[c])
            ST_NORMAL: begin
               if (sig && !chan_last[c]) begin
                  chan_model[c] = ST_ON_DELAY;
                  chan_start[c] = now;
               end
            end
            ST_ON_DELAY: begin
               if (!sig) begin
                  chan_model[c] = ST_NORMAL;
               end else if (elapsed > {16'd0, cfg_settle}) begin
                  if (has_hold) begin
                     chan_model[c] = ST_HOLD;
                     chan_start[c] = now;
                  end else begin
                     chan_model[c] = ST_RUN;
                     log_bits[c] = 1'b1;
                     upd = 1'b1;
                     shown_code = run_pattern_code();
                  end
               end
            end
            ST_HOLD: begin
               if (!sig) begin
                  chan_model[c] = ST_NORMAL;
               end else if (elapsed > hold_ms) begin
                  chan_model[c] = ST_RUN;
                  log_bits[c] = 1'b1;
                  upd = 1'b1;
                  shown_code = run_pattern_code();
               end
            end
            ST_OFF_DELAY: begin
               if (sig) begin
                  chan_model[c] = ST_RUN;
               end else if (elapsed > {16'd0, cfg_settle}) begin
                  chan_model[c] = ST_NORMAL;
                  upd = 1'b1;
                  shown_code = run_pattern_code();
               end
            end
            ST_RUN: begin
               if (!sig) begin
                  chan_model[c] = ST_OFF_DELAY;
                  chan_start[c] = now;
               end
            end
            default: ;
         endcase
         chan_last[c] = sig;
      end
   endtask

   task automatic predict_poll(input req_type p);
      rsp_type    r;
      logic [2:0] log_bits;
      logic       upd;
      logic       raised;
      logic       cleared;
      logic       any_run;
      logic       gate_sig;
      logic       ir_sig;
      log_bits = 3'b000;
      upd      = 1'b0;
      raised   = 1'b0;
      cleared  = 1'b0;
      if (p.confirm) begin
         master_on = 1'b0;
         cleared   = 1'b1;
         for (int c = 0; c < 3; c++)
            if (chan_model[c] == ST_RUN) chan_model[c] = ST_NORMAL;
         upd        = 1'b1;
         shown_code = CODE_CONFIRM;
      end
      advance_channel(CH_TAMPER, cfg_enable[0], p.tamper_level, p.now_ms, 1'b0, 32'd0,
                      log_bits, upd);
      // two gate inputs combine by or; two infrared inputs use input 1
      gate_sig = ((cfg_role1 == ROLE_GATE) && (p.input1_level == cfg_gate_hi)) ||
                 ((cfg_role2 == ROLE_GATE) && (p.input2_level == cfg_gate_hi));
      advance_channel(CH_GATE,
                      cfg_enable[1] && (cfg_role1 == ROLE_GATE || cfg_role2 == ROLE_GATE),
                      gate_sig, p.now_ms, 1'b1, {16'd0, cfg_gate_hold} * 32'd1000,
                      log_bits, upd);
      ir_sig = ((cfg_role1 == ROLE_INFRARED) ? p.input1_level : p.input2_level) == cfg_ir_hi;
      advance_channel(CH_IR,
                      cfg_enable[2] && (cfg_role1 == ROLE_INFRARED || cfg_role2 == ROLE_INFRARED),
                      ir_sig, p.now_ms, 1'b1, {16'd0, cfg_ir_hold} * 32'd1000,
                      log_bits, upd);
      any_run = chan_model[CH_TAMPER] == ST_RUN || chan_model[CH_GATE] == ST_RUN ||
                chan_model[CH_IR] == ST_RUN;
      if (!master_on) begin
         if (any_run) begin
            master_on = 1'b1;
            raised    = 1'b1;
         end
      end else if (!any_run) begin
         master_on = 1'b0;
         cleared   = 1'b1;
      end
      r.alarm_active    = master_on;
      r.alarm_raised    = raised;
      r.alarm_cleared   = cleared;
      r.log_mask        = log_bits;
      r.display_update  = upd;
      r.display_code    = shown_code;
      r.tamper_status   = chan_model[CH_TAMPER];
      r.gate_status     = chan_model[CH_GATE];
      r.infrared_status = chan_model[CH_IR];
      expected_polls.push_back(r);
   endtask

   task automatic mirror_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      case (idx)
         REG_ENABLE_MASK:   cfg_enable    = d[2:0];
         REG_IR_ACT_HIGH:   cfg_ir_hi     = d[0];
         REG_GATE_ACT_HIGH: cfg_gate_hi   = d[0];
         REG_INPUT1_ROLE:   cfg_role1     = d[1:0];
         REG_INPUT2_ROLE:   cfg_role2     = d[1:0];
         REG_IR_HOLD_S:     cfg_ir_hold   = d;
         REG_GATE_HOLD_S:   cfg_gate_hold = d;
         REG_SETTLE_MS:     cfg_settle    = d;
         default: ;
      endcase
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_polls.size() == 0) begin
         error_count++;
         if (error_count <= 10)
            $display("mismatch at cycle %0d: result %h with no poll outstanding",
                     cycle_count, got);
      end else begin
         want = expected_polls.pop_front();
         if (got.alarm_active !== want.alarm_active || got.alarm_raised !== want.alarm_raised ||
             got.alarm_cleared !== want.alarm_cleared || got.log_mask !== want.log_mask ||
             got.display_update !== want.display_update ||
             got.display_code !== want.display_code ||
             got.tamper_status !== want.tamper_status ||
             got.gate_status !== want.gate_status ||
             got.infrared_status !== want.infrared_status) begin
            error_count++;
            if (error_count <= 10) begin
               $display("mismatch at cycle %0d (exp/got): active %b/%b raised %b/%b cleared %b/%b",
                        cycle_count, want.alarm_active, got.alarm_active,
                        want.alarm_raised, got.alarm_raised, want.alarm_cleared,
                        got.alarm_cleared);
               $display("   log %b/%b upd %b/%b code %0d/%0d status t %0d/%0d g %0d/%0d i %0d/%0d",
                        want.log_mask, got.log_mask,
                        want.display_update, got.display_update, want.display_code,
                        got.display_code, want.tamper_status, got.tamper_status,
                        want.gate_status, got.gate_status, want.infrared_status,
                        got.infrared_status);
            end
         end
      end
   endtask

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      cycle_count++;
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (csr_we) mirror_reg(csr_index, csr_wdata);
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            polls_accepted++;
            predict_poll(req_data);
         end
      end
   end

   // ---------------------------------------------------------------- driver

   always @(negedge clock) begin : drive_polls
      logic    next_valid;
      req_type next_data;
      next_valid = 1'b0;
      next_data  = req_data;
      if (reset) begin
         next_valid = 1'b0;
      end else if (req_valid && !req_taken) begin
         next_valid = 1'b1;
      end else if (drain_hold) begin
         // hold off until every outstanding result is back
         if (expected_polls.size() == 0) drain_hold = 1'b0;
      end else if (gap_left > 0) begin
         gap_left--;
      end else if (pending_polls.size() > 0) begin
         next_valid = 1'b1;
         next_data  = pending_polls.pop_front();
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if ($urandom_range(0, 19) == 0) drain_hold = 1'b1;
         end
      end
      req_valid <= next_valid;
      req_data  <= next_data;
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = flow_type'($urandom_range(0, 3));
         stall_left = $urandom_range(8, 64);
      end else begin
         stall_left--;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         case (stall_mode)
            FLOW_FREE:  rsp_stall <= 1'b0;
            FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            FLOW_HALF:  rsp_stall <= 1'($urandom_range(0, 1));
            default:    rsp_stall <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic push_poll(input logic [31:0] now, input logic cf, input logic tp,
                            input logic i1, input logic i2);
      req_type p;
      p.now_ms       = now;
      p.confirm      = cf;
      p.tamper_level = tp;
      p.input1_level = i1;
      p.input2_level = i2;
      pending_polls.push_back(p);
      polls_queued++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
   endtask

   task automatic program_regs(input logic [2:0] en, input logic ir_hi, input logic gate_hi,
                               input logic [1:0] r1, input logic [1:0] r2,
                               input logic [15:0] ir_hold, input logic [15:0] gate_hold,
                               input logic [15:0] settle);
      write_reg(REG_ENABLE_MASK, {13'd0, en});
      write_reg(REG_IR_ACT_HIGH, {15'd0, ir_hi});
      write_reg(REG_GATE_ACT_HIGH, {15'd0, gate_hi});
      write_reg(REG_INPUT1_ROLE, {14'd0, r1});
      write_reg(REG_INPUT2_ROLE, {14'd0, r2});
      write_reg(REG_IR_HOLD_S, ir_hold);
      write_reg(REG_GATE_HOLD_S, gate_hold);
      write_reg(REG_SETTLE_MS, settle);
      @(negedge clock);
      csr_we <= 1'b0;
      // new polls are queued on a rising edge, away from the driver
      @(posedge clock);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (polls_accepted != polls_queued || expected_polls.size() != 0);
   endtask

   // time advance between polls, aimed at the delay boundaries of the current setting
   function automatic logic [31:0] next_step();
      logic [31:0] hold_ms;
      hold_ms = {16'd0, ($urandom_range(0, 1) ? cfg_ir_hold : cfg_gate_hold)} * 32'd1000;
      case ($urandom_range(0, 15))
         0, 1, 2, 3: return $urandom_range(0, 3);
         4, 5, 6:    return {16'd0, cfg_settle} + $urandom_range(0, 1);
         7, 8:       return hold_ms + $urandom_range(0, 1);
         9, 10:      return $urandom_range(0, cfg_settle + 2);
         11:         return $urandom;
         default:    return $urandom_range(1, 40);
      endcase
   endfunction

   task automatic queue_random_polls(input int n);
      logic cf;
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 19) == 0) begin
            // noise: levels scrambled
            {lv_tamper, lv_in1, lv_in2} = 3'($urandom_range(0, 7));
            poll_ms += $urandom_range(0, 5);
         end else begin
            // mostly steady levels so the qualifiers get through their delays
            if ($urandom_range(0, 5) == 0) lv_tamper = !lv_tamper;
            if ($urandom_range(0, 5) == 0) lv_in1 = !lv_in1;
            if ($urandom_range(0, 5) == 0) lv_in2 = !lv_in2;
            poll_ms += next_step();
         end
         cf = ($urandom_range(0, 24) == 0);
         push_poll(poll_ms, cf, lv_tamper, lv_in1, lv_in2);
      end
   endtask

   task automatic random_setting();
      logic [2:0]  en;
      logic [15:0] holds [2];
      logic [15:0] settle;
      en = $urandom_range(0, 1) ? (EN_TAMPER | EN_GATE | EN_IR) : 3'($urandom_range(0, 7));
      for (int h = 0; h < 2; h++) begin
         case ($urandom_range(0, 7))
            0:       holds[h] = 16'hFFFF;
            1:       holds[h] = 16'($urandom_range(0, 16'hFFFF));
            default: holds[h] = 16'($urandom_range(0, 3));
         endcase
      end
      case ($urandom_range(0, 7))
         0:       settle = 16'd0;
         1:       settle = 16'hFFFF;
         2:       settle = 16'($urandom_range(0, 16'hFFFF));
         default: settle = 16'($urandom_range(1, 3000));
      endcase
      program_regs(en, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                   holds[0], holds[1], settle);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: every channel disabled, confirm alone still clears
      push_poll(32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b1);
      push_poll(32'd5000, 1'b1, 1'b1, 1'b0, 1'b0);
      push_poll(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, 1'b0);
      wait_drained();

      // zero delays, across the timestamp wrap; equal elapsed does not expire
      program_regs(EN_TAMPER | EN_GATE | EN_IR, 1'b1, 1'b1, ROLE_GATE, ROLE_INFRARED,
                   16'd0, 16'd0, 16'd0);
      push_poll(32'hFFFF_FFFE, 1'b0, 1'b0, 1'b0, 1'b0);
      push_poll(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1);
      push_poll(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b1);
      push_poll(32'h0000_0000, 1'b0, 1'b1, 1'b1, 1'b1);
      push_poll(32'h0000_0001, 1'b0, 1'b1, 1'b1, 1'b1);
      push_poll(32'h0000_0001, 1'b1, 1'b1, 1'b1, 1'b1);
      push_poll(32'h0000_0002, 1'b0, 1'b0, 1'b0, 1'b0);
      push_poll(32'h0000_0003, 1'b0, 1'b1, 1'b1, 1'b1);
      push_poll(32'h0000_0005, 1'b0, 1'b1, 1'b1, 1'b1);
      push_poll(32'h0000_0007, 1'b0, 1'b1, 1'b1, 1'b1);
      push_poll(32'h0000_0008, 1'b0, 1'b0, 1'b0, 1'b0);
      push_poll(32'h0000_0008, 1'b0, 1'b1, 1'b1, 1'b1);
      push_poll(32'h0000_0009, 1'b0, 1'b0, 1'b0, 1'b0);
      push_poll(32'h0000_000B, 1'b0, 1'b0, 1'b0, 1'b0);
      poll_ms = 32'h0000_000B;
      queue_random_polls(45);
      wait_drained();

      // both inputs on the gate, active low, infrared unassigned
      program_regs(EN_TAMPER | EN_GATE | EN_IR, 1'b0, 1'b0, ROLE_GATE, ROLE_GATE,
                   16'd1, 16'd1, 16'd1000);
      push_poll(32'h8000_0000, 1'b0, 1'b0, 1'b1, 1'b1);
      push_poll(32'h8000_07D0, 1'b0, 1'b0, 1'b1, 1'b1);
      push_poll(32'h8000_07D1, 1'b0, 1'b1, 1'b0, 1'b1);
      push_poll(32'h8000_0BB9, 1'b0, 1'b1, 1'b0, 1'b1);
      push_poll(32'h8000_0BBA, 1'b0, 1'b1, 1'b0, 1'b1);
      push_poll(32'h8000_0FA2, 1'b0, 1'b1, 1'b0, 1'b1);
      push_poll(32'h8000_0FA3, 1'b0, 1'b1, 1'b0, 1'b1);
      push_poll(32'h8000_0FA3, 1'b0, 1'b1, 1'b1, 1'b0);
      push_poll(32'h8000_0FA4, 1'b0, 1'b0, 1'b1, 1'b1);
      push_poll(32'h8000_138D, 1'b0, 1'b0, 1'b1, 1'b1);
      poll_ms = 32'h8000_138D;
      queue_random_polls(45);
      wait_drained();

      // gate disabled, both inputs on infrared, longest settle
      program_regs(EN_TAMPER | EN_IR, 1'b1, 1'b0, ROLE_INFRARED, ROLE_INFRARED,
                   16'd2, 16'd2, 16'hFFFF);
      queue_random_polls(45);
      wait_drained();

      // longest holds, spare role on input 1
      program_regs(EN_TAMPER | EN_GATE | EN_IR, 1'b1, 1'b1, ROLE_SPARE, ROLE_INFRARED,
                   16'hFFFF, 16'hFFFF, 16'hFFFF);
      queue_random_polls(40);
      wait_drained();

      // gate on input 2 with infrared on input 1, tamper off
      program_regs(EN_GATE | EN_IR, 1'b0, 1'b1, ROLE_INFRARED, ROLE_GATE,
                   16'd0, 16'd3, 16'd1);
      queue_random_polls(45);
      wait_drained();

      program_regs(EN_TAMPER, 1'b0, 1'b0, ROLE_OTHER, ROLE_OTHER, 16'd0, 16'd0, 16'd20);
      queue_random_polls(20);
      wait_drained();

      for (int ph = 0; ph < 6; ph++) begin
         random_setting();
         queue_random_polls(45);
         wait_drained();
      end

      repeat (8) @(negedge clock);
      if (error_count == 0 && expected_polls.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      while (cycle_count < RUN_LIMIT) @(negedge clock);
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

>>> three_channel_alarm_qualifier.f
design/tcaq_pkg.sv
design/three_channel_alarm_qualifier.sv
tb/sv/tb_top.sv
